>>> rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DSFP_ASSERT_IF(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DSFP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/dsfp_pkg.sv
package dsfp_pkg;

  // frame layout
  localparam logic [7:0]  HdrFirst    = 8'h42;
  localparam logic [7:0]  HdrSecond   = 8'h4D;
  localparam logic [15:0] GoodLength  = 16'd28;
  localparam logic [4:0]  SumEndPos   = 5'd30;
  localparam logic [4:0]  HdrPos      = 5'd1;
  localparam logic [4:0]  LenPos      = 5'd3;
  localparam logic [4:0]  FirstWrdPos = 5'd5;
  localparam logic [4:0]  LastWrdPos  = 5'd27;
  localparam logic [4:0]  VersionPos  = 5'd28;
  localparam logic [4:0]  ErrCodePos  = 5'd29;
  localparam logic [4:0]  FramePosEnd = 5'd31;

  // result words
  localparam int          NumWords    = 14;
  localparam logic [3:0]  VersionIdx  = 4'd12;
  localparam logic [3:0]  ErrCodeIdx  = 4'd13;
  localparam logic [3:0]  LastIdx     = 4'd13;

  // word store: two banks of NumWords entries
  localparam int          RamDepth    = 2 * NumWords;
  localparam int          RamAw       = $clog2(RamDepth);
  localparam logic [RamAw-1:0] BankOffset = RamAw'(NumWords);

  // status codes
  localparam logic [1:0]  StOk        = 2'd0;
  localparam logic [1:0]  StChecksum  = 2'd1;
  localparam logic [1:0]  StHeader    = 2'd2;
  localparam logic [1:0]  StLength    = 2'd3;

  typedef struct packed {
    logic             en;
    logic [RamAw-1:0] addr;
    logic [15:0]      data;
  } ram_wr_t;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [1:0] status;
    logic       bank;
  } frame_end_t;

endpackage

>>> rtl/dsfp_ram.sv
module dsfp_ram #(
  parameter int Width = 16,
  parameter int Depth = 28
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/dsfp_frame_rx.sv
module dsfp_frame_rx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 at_end_o,
  output dsfp_pkg::ram_wr_t    wr_o,
  output dsfp_pkg::frame_end_t end_o
);

  logic [4:0]  pos_q,  pos_d;
  logic [15:0] sum_q,  sum_d;
  logic        hdr_q,  hdr_d;
  logic [15:0] len_q,  len_d;
  logic [7:0]  pend_q, pend_d;
  logic        bank_q, bank_d;
  logic [15:0] pair;
  logic [3:0]  widx;
  logic [1:0]  st;

  assign pair = {pend_q, rx_byte_i};
  assign at_end_o = (pos_q == dsfp_pkg::FramePosEnd);

  // byte position, checksum, header and length tracking
  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    hdr_d  = hdr_q;
    len_d  = len_q;
    pend_d = pend_q;
    bank_d = bank_q;
    if (accept_i) begin
      pos_d = pos_q + 5'd1;
      if (pos_q == 5'd0) begin
        sum_d = {8'd0, rx_byte_i};
      end else if (pos_q < dsfp_pkg::SumEndPos) begin
        sum_d = sum_q + {8'd0, rx_byte_i};
      end
      if (pos_q == dsfp_pkg::HdrPos) begin
        hdr_d = (pend_q == dsfp_pkg::HdrFirst) && (rx_byte_i == dsfp_pkg::HdrSecond);
      end
      if (pos_q == dsfp_pkg::LenPos) begin
        len_d = pair;
      end
      if (!pos_q[0]) begin
        pend_d = rx_byte_i;
      end
      if (at_end_o) begin
        bank_d = ~bank_q;
      end
    end
  end

  // word store write, odd positions 5..27 carry the low byte of a data word, 28 and 29 a lone byte
  always_comb begin
    widx = 4'd0;
    wr_o = '0;
    if (pos_q >= dsfp_pkg::FirstWrdPos && pos_q <= dsfp_pkg::LastWrdPos && pos_q[0]) begin
      widx    = pos_q[4:1] - 4'd2;
      wr_o.en = accept_i;
      wr_o.data = pair;
    end else if (pos_q == dsfp_pkg::VersionPos) begin
      widx    = dsfp_pkg::VersionIdx;
      wr_o.en = accept_i;
      wr_o.data = {8'd0, rx_byte_i};
    end else if (pos_q == dsfp_pkg::ErrCodePos) begin
      widx    = dsfp_pkg::ErrCodeIdx;
      wr_o.en = accept_i;
      wr_o.data = {8'd0, rx_byte_i};
    end
    wr_o.addr = bank_q ? (dsfp_pkg::RamAw'(widx) + dsfp_pkg::BankOffset)
                       : dsfp_pkg::RamAw'(widx);
  end

  // frame checks, in order checksum, header, length
  always_comb begin
    if (pair != sum_q) begin
      st = dsfp_pkg::StChecksum;
    end else if (!hdr_q) begin
      st = dsfp_pkg::StHeader;
    end else if (len_q != dsfp_pkg::GoodLength) begin
      st = dsfp_pkg::StLength;
    end else begin
      st = dsfp_pkg::StOk;
    end
    end_o.valid  = accept_i && at_end_o;
    end_o.ok     = (st == dsfp_pkg::StOk);
    end_o.status = st;
    end_o.bank   = bank_q;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      hdr_q  <= 1'b0;
      len_q  <= '0;
      pend_q <= '0;
      bank_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      hdr_q  <= hdr_d;
      len_q  <= len_d;
      pend_q <= pend_d;
      bank_q <= bank_d;
    end
  end

endmodule

>>> rtl/dsfp_drain.sv
module dsfp_drain (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dsfp_pkg::frame_end_t         end_i,
  output logic                         busy_o,
  output logic                         rd_en_o,
  output logic [dsfp_pkg::RamAw-1:0]   rd_addr_o,
  input  logic [15:0]                  rd_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   word_index_o,
  output logic [15:0]                  word_value_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] value;
    logic [1:0]  st;
    logic        last;
  } item_t;

  // drain job
  logic       job_act_q, job_act_d;
  logic       job_ok_q,  job_ok_d;
  logic [1:0] job_st_q,  job_st_d;
  logic       job_bank_q, job_bank_d;
  logic [3:0] job_idx_q, job_idx_d;

  // read stage, aligned with the memory read data
  logic       s1_vld_q;
  logic [3:0] s1_idx_q;
  logic [1:0] s1_st_q;
  logic       s1_last_q;
  logic       s1_mem_q;

  // two-entry result queue
  item_t      q_mem_q [2];
  logic       q_wp_q, q_rp_q;
  logic [1:0] q_cnt_q, q_cnt_d;

  logic       pop;
  logic       issue;
  logic       is_last;
  logic [1:0] room;
  item_t      push_item;

  assign pop     = out_valid_o && out_ready_i;
  assign room    = q_cnt_q + {1'b0, s1_vld_q} - {1'b0, pop};
  assign issue   = job_act_q && (room < 2'd2);
  assign is_last = !job_ok_q || (job_idx_q == dsfp_pkg::LastIdx);
  assign busy_o  = job_act_q;

  assign rd_en_o   = issue && job_ok_q;
  assign rd_addr_o = job_bank_q ? (dsfp_pkg::RamAw'(job_idx_q) + dsfp_pkg::BankOffset)
                                : dsfp_pkg::RamAw'(job_idx_q);

  // job sequencing
  always_comb begin
    job_act_d  = job_act_q;
    job_ok_d   = job_ok_q;
    job_st_d   = job_st_q;
    job_bank_d = job_bank_q;
    job_idx_d  = job_idx_q;
    if (end_i.valid) begin
      job_act_d  = 1'b1;
      job_ok_d   = end_i.ok;
      job_st_d   = end_i.status;
      job_bank_d = end_i.bank;
      job_idx_d  = 4'd0;
    end else if (issue) begin
      job_idx_d = job_idx_q + 4'd1;
      if (is_last) begin
        job_act_d = 1'b0;
      end
    end
  end

  // item leaving the read stage
  always_comb begin
    push_item.idx   = s1_idx_q;
    push_item.value = s1_mem_q ? rd_data_i : 16'd0;
    push_item.st    = s1_st_q;
    push_item.last  = s1_last_q;
    q_cnt_d = q_cnt_q + {1'b0, s1_vld_q} - {1'b0, pop};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_act_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      q_wp_q    <= 1'b0;
      q_rp_q    <= 1'b0;
      q_cnt_q   <= '0;
    end else begin
      job_act_q <= job_act_d;
      s1_vld_q  <= issue;
      q_cnt_q   <= q_cnt_d;
      if (s1_vld_q) begin
        q_wp_q <= ~q_wp_q;
      end
      if (pop) begin
        q_rp_q <= ~q_rp_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_ok_q   <= job_ok_d;
    job_st_q   <= job_st_d;
    job_bank_q <= job_bank_d;
    job_idx_q  <= job_idx_d;
    if (issue) begin
      s1_idx_q  <= job_ok_q ? job_idx_q : 4'd0;
      s1_st_q   <= job_st_q;
      s1_last_q <= is_last;
      s1_mem_q  <= job_ok_q;
    end
    if (s1_vld_q) begin
      q_mem_q[q_wp_q] <= push_item;
    end
  end

  assign out_valid_o  = (q_cnt_q != 2'd0);
  assign word_index_o = q_mem_q[q_rp_q].idx;
  assign word_value_o = q_mem_q[q_rp_q].value;
  assign status_o     = q_mem_q[q_rp_q].st;
  assign last_o       = q_mem_q[q_rp_q].last;

endmodule

>>> rtl/dust_sensor_frame_parser_unit.sv
// 32-byte particle sensor frame parser.
// Input channel: one received byte per beat (rx_byte_i, in_valid_i/in_ready_o).
// Output channel: decoded results (word_index_o, word_value_o, status_o, last_o)
// with out_valid_o/out_ready_i. A good frame gives 14 beats: twelve data
// words, version and sensor error code, last_o on the final one. A bad frame
// gives a single beat with the first failing check in status_o.
// Throughput: one input byte per cycle unless held off at byte 31. Data words
// go into a two-bank word RAM as they arrive; after byte 31 the finished bank
// is read out one word per cycle while the output does not stall, while the
// next frame fills the other bank. Accepting byte 31 starts the readout; each
// result passes the job registers, the RAM read stage and the result queue.
// Back-pressure: a two-entry result queue absorbs output stalls; the input is
// held off only at byte 31 of a frame while the previous frame's readout has
// not issued its last item.
// Reset: byte position returns to frame start, sums and checks clear, the
// result queue empties. Word RAM contents are not cleared.
module dust_sensor_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic                       accept;
  logic                       at_end;
  logic                       busy;
  dsfp_pkg::ram_wr_t          wr;
  dsfp_pkg::frame_end_t       frm_end;
  logic                       rd_en;
  logic [dsfp_pkg::RamAw-1:0] rd_addr;
  logic [15:0]                rd_data;

  // hold the closing byte until the previous readout has been issued
  assign in_ready_o = !(at_end && busy);
  assign accept     = in_valid_i && in_ready_o;

  dsfp_frame_rx u_frame_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .at_end_o  (at_end),
    .wr_o      (wr),
    .end_o     (frm_end)
  );

  dsfp_ram #(
    .Width (16),
    .Depth (dsfp_pkg::RamDepth)
  ) u_word_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr.en),
    .wr_addr_i (wr.addr),
    .wr_data_i (wr.data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dsfp_drain u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .end_i        (frm_end),
    .busy_o       (busy),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

>>> rtl/dsfp_checker.sv
`include "assert_macros.svh"

module dsfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  word_index_i,
  input logic [15:0] word_value_i,
  input logic [1:0]  status_i,
  input logic        last_i
);

  // a stalled result beat stays offered
  `DSFP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped while stalled")

  // an error beat is a lone, zeroed, final beat
  `DSFP_ASSERT_IF(a_err_shape, out_valid_i && (status_i != dsfp_pkg::StOk), last_i && (word_index_i == 4'd0) && (word_value_i == 16'd0), "malformed error beat")

  // a good frame closes on the sensor error code
  `DSFP_ASSERT_IF(a_ok_last, out_valid_i && last_i && (status_i == dsfp_pkg::StOk), word_index_i == dsfp_pkg::LastIdx, "good frame closed early")

  // beats before the last are good words below the last index
  `DSFP_ASSERT_IF(a_mid_beat, out_valid_i && !last_i, (status_i == dsfp_pkg::StOk) && (word_index_i < dsfp_pkg::LastIdx), "bad non-final beat")

  // words of a good frame come in order
  `DSFP_ASSERT_NEXT(a_idx_step, out_valid_i && out_ready_i && !last_i, !out_valid_i || (word_index_i == $past(word_index_i) + 4'd1), "word index skipped")

endmodule

bind dust_sensor_frame_parser_unit dsfp_checker u_dsfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .word_index_i (word_index_o),
  .word_value_i (word_value_o),
  .status_i     (status_o),
  .last_i       (last_o)
);
